// ----- rtl/smf_pkg.sv -----
// Shared constants and types of the sliding median filter.
package smf_pkg;

    // Widest median window and sample width.
    localparam int MAX_WINDOW  = 101;
    localparam int SAMPLE_BITS = 32;

    // Half window limit and the widths that follow from it.
    localparam int HALF_MAX = MAX_WINDOW / 2;
    localparam int HALF_W   = $clog2(HALF_MAX + 1);
    localparam int LEN_W    = $clog2(MAX_WINDOW + 1);

    // Window size register and per-record sample counter.
    localparam int                CFG_W        = 7;
    localparam int                COUNT_W      = 7;
    localparam logic [CFG_W-1:0]  WINDOW_RESET = CFG_W'(5);

    // Ring of recent samples for raw reads: the deepest raw read is HALF_MAX back.
    localparam int RING_DEPTH = HALF_MAX + 1;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // One classified sample as handed from the front end to the back end.
    typedef struct packed {
        t_sample           sample;
        logic [HALF_W-1:0] half;
        logic [HALF_W-1:0] start;
        logic              emit;
        logic              med;
        logic              last;
    } t_item;

    // Commands to the median cell array.
    typedef struct packed {
        logic              load;
        logic              count;
        logic              rotate;
        logic [LEN_W-1:0]  len;
        logic [HALF_W-1:0] half;
    } t_med_ctrl;

    // Status seen at the head cell of the array.
    typedef struct packed {
        logic    hit;
        t_sample value;
    } t_med_stat;

endpackage

// ----- rtl/smf_front.sv -----
// Front end: window size register, record position tracking and sample classification.
module smf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [smf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  smf_pkg::t_sample            i_sample,
    input  logic                        i_end_of_record,
    output logic                        o_q_push,
    output smf_pkg::t_item              o_q_item,
    input  logic                        i_q_full
);

    localparam int CMP_W = smf_pkg::COUNT_W + 1;
    localparam logic [smf_pkg::CFG_W-2:0] HALF_CAP = (smf_pkg::CFG_W - 1)'(smf_pkg::HALF_MAX);

    logic [smf_pkg::CFG_W-1:0]   r_window_size;
    logic [smf_pkg::COUNT_W-1:0] r_seen_count;
    logic [smf_pkg::COUNT_W-1:0] n_seen_count;
    logic [smf_pkg::CFG_W-2:0]   half_raw;
    logic [smf_pkg::HALF_W-1:0]  half;
    logic [CMP_W-1:0]            seen_ext;
    logic                        accept;
    logic                        emit;
    logic                        med;

    // The register write channel never stalls.
    assign o_cfg_ready = 1'b1;

    // Half width, saturated so the window fits the cell array.
    assign half_raw = r_window_size[smf_pkg::CFG_W-1:1];
    assign half     = (half_raw > HALF_CAP) ? smf_pkg::HALF_W'(smf_pkg::HALF_MAX)
                                            : smf_pkg::HALF_W'(half_raw);

    // A sample falls due once half samples follow it; its window is full after twice that.
    assign seen_ext = CMP_W'(r_seen_count);
    assign emit     = seen_ext >= CMP_W'(half);
    assign med      = (seen_ext >= CMP_W'({half, 1'b0})) && (half != '0);

    assign accept   = push && !full;
    assign full     = i_q_full;
    assign o_q_push = accept;

    // Classified beat for the back end.
    always_comb begin
        o_q_item.sample = i_sample;
        o_q_item.half   = half;
        o_q_item.start  = emit ? half
                               : smf_pkg::HALF_W'(r_seen_count) + smf_pkg::HALF_W'(1);
        o_q_item.emit   = emit;
        o_q_item.med    = med;
        o_q_item.last   = i_end_of_record;
    end

    // Saturating sample count, cleared after each end marker.
    always_comb begin
        n_seen_count = r_seen_count;
        if (accept) begin
            if (i_end_of_record) begin
                n_seen_count = '0;
            end else if (r_seen_count != '1) begin
                n_seen_count = r_seen_count + smf_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= smf_pkg::WINDOW_RESET;
            r_seen_count  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_window_size <= i_cfg_data;
            end
            r_seen_count <= n_seen_count;
        end
    end

endmodule

// ----- rtl/smf_queue.sv -----
// Short queue of classified samples between the front end and the back end.
module smf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smf_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output smf_pkg::t_item o_item,
    output logic           o_empty
);

    smf_pkg::t_item                r_mem [smf_pkg::QUEUE_DEPTH];
    logic [smf_pkg::QUEUE_AW-1:0]  r_wr;
    logic [smf_pkg::QUEUE_AW-1:0]  r_rd;
    logic [smf_pkg::QUEUE_AW:0]    r_count;

    assign o_full  = r_count == (smf_pkg::QUEUE_AW + 1)'(smf_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers wrap naturally at the power-of-two depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + smf_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + smf_pkg::QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (smf_pkg::QUEUE_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (smf_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/smf_median.sv -----
// Median cell array: a shift line of samples with per-cell rank counters.
module smf_median (
    input  logic               i_clk,
    input  smf_pkg::t_med_ctrl i_ctrl,
    input  smf_pkg::t_sample   i_sample,
    output smf_pkg::t_med_stat o_stat
);

    smf_pkg::t_sample           r_val [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::LEN_W-1:0]  r_lt  [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::LEN_W-1:0]  r_le  [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::LEN_W-1:0]  upd_lt [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::LEN_W-1:0]  upd_le [smf_pkg::MAX_WINDOW];
    smf_pkg::t_sample           bcast;
    logic [smf_pkg::LEN_W-1:0]  half_ext;

    // The head cell's sample is compared against every cell of the window.
    assign bcast = r_val[0];

    always_comb begin
        for (int k = 0; k < smf_pkg::MAX_WINDOW; k++) begin
            upd_lt[k] = r_lt[k] + smf_pkg::LEN_W'(r_val[k] < bcast);
            upd_le[k] = r_le[k] + smf_pkg::LEN_W'(r_val[k] <= bcast);
        end
    end

    // Each cell shifts on load and rotates toward the head inside the active window.
    for (genvar k = 0; k < smf_pkg::MAX_WINDOW; k++) begin : g_cell
        localparam int NEXT = (k == smf_pkg::MAX_WINDOW - 1) ? 0 : k + 1;
        localparam int PREV = (k == 0) ? 0 : k - 1;

        logic             in_ring;
        logic             wrap;
        smf_pkg::t_sample shift_val;

        assign in_ring   = smf_pkg::LEN_W'(k) < i_ctrl.len;
        assign wrap      = smf_pkg::LEN_W'(k) == (i_ctrl.len - smf_pkg::LEN_W'(1));
        assign shift_val = (k == 0) ? i_sample : r_val[PREV];

        always_ff @(posedge i_clk) begin
            if (i_ctrl.load) begin
                r_val[k] <= shift_val;
                r_lt[k]  <= '0;
                r_le[k]  <= '0;
            end else if ((i_ctrl.count || i_ctrl.rotate) && in_ring) begin
                if (wrap) begin
                    r_val[k] <= r_val[0];
                    r_lt[k]  <= i_ctrl.count ? upd_lt[0] : r_lt[0];
                    r_le[k]  <= i_ctrl.count ? upd_le[0] : r_le[0];
                end else begin
                    r_val[k] <= r_val[NEXT];
                    r_lt[k]  <= i_ctrl.count ? upd_lt[NEXT] : r_lt[NEXT];
                    r_le[k]  <= i_ctrl.count ? upd_le[NEXT] : r_le[NEXT];
                end
            end
        end
    end

    // The head sample is the median when its rank range covers the middle position.
    assign half_ext     = smf_pkg::LEN_W'(i_ctrl.half);
    assign o_stat.hit   = (r_lt[0] <= half_ext) && (half_ext < r_le[0]);
    assign o_stat.value = r_val[0];

endmodule

// ----- rtl/smf_back.sv -----
// Back end: sample ring, median sequencing, raw flushes and the result register.
module smf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  smf_pkg::t_item   i_q_item,
    output logic             empty,
    input  logic             pop,
    output smf_pkg::t_sample o_filtered,
    output logic             o_last_out
);

    localparam int SUM_W = smf_pkg::RING_AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COUNT,
        S_SELECT,
        S_EMIT
    } t_state;

    t_state                        r_state;
    smf_pkg::t_item                r_item;
    logic [smf_pkg::RING_AW-1:0]   r_head;
    logic [smf_pkg::RING_AW-1:0]   head_next;
    smf_pkg::t_sample              r_ring [smf_pkg::RING_DEPTH];
    smf_pkg::t_sample              r_rdata;
    logic [smf_pkg::HALF_W-1:0]    r_rd_k;
    logic [smf_pkg::HALF_W-1:0]    r_flush_left;
    logic [smf_pkg::LEN_W-1:0]     r_step;
    logic                          r_found;
    logic                          r_from_mem;
    smf_pkg::t_sample              r_med;
    logic                          r_out_valid;
    logic                          n_out_valid;
    smf_pkg::t_sample              r_out_val;
    logic                          r_out_last;

    logic                          slot_free;
    logic [smf_pkg::LEN_W-1:0]     len;
    logic                          step_last;
    logic                          rd_en;
    logic [smf_pkg::HALF_W-1:0]    rd_k;
    logic [SUM_W-1:0]              head_ext;
    logic [SUM_W-1:0]              k_ext;
    logic [smf_pkg::RING_AW-1:0]   rd_addr;
    smf_pkg::t_med_ctrl            med_ctrl;
    smf_pkg::t_med_stat            med_stat;

    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign slot_free = !r_out_valid || pop;
    assign len       = smf_pkg::LEN_W'({r_item.half, 1'b0}) + smf_pkg::LEN_W'(1);
    assign step_last = r_step == (len - smf_pkg::LEN_W'(1));

    // The result register fills from the emit state and drains on pop.
    assign n_out_valid = ((r_state == S_EMIT) && slot_free) || (r_out_valid && !pop);

    // Median cell array control.
    always_comb begin
        med_ctrl.load   = o_q_pop;
        med_ctrl.count  = r_state == S_COUNT;
        med_ctrl.rotate = r_state == S_SELECT;
        med_ctrl.len    = len;
        med_ctrl.half   = r_item.half;
    end

    smf_median u_median (
        .i_clk    (i_clk),
        .i_ctrl   (med_ctrl),
        .i_sample (i_q_item.sample),
        .o_stat   (med_stat)
    );

    // Raw reads: one after the load, then one per emitted beat while a flush runs.
    always_comb begin
        rd_en = 1'b0;
        rd_k  = r_rd_k;
        if (r_state == S_READ) begin
            rd_en = 1'b1;
        end else if ((r_state == S_EMIT) && slot_free && (r_flush_left != '0)) begin
            rd_en = 1'b1;
            rd_k  = r_flush_left - smf_pkg::HALF_W'(1);
        end
    end

    // Ring address of the sample rd_k places before the newest.
    assign head_ext  = SUM_W'(r_head);
    assign k_ext     = SUM_W'(rd_k);
    assign rd_addr   = (head_ext >= k_ext)
                     ? smf_pkg::RING_AW'(head_ext - k_ext)
                     : smf_pkg::RING_AW'(head_ext + SUM_W'(smf_pkg::RING_DEPTH) - k_ext);
    assign head_next = (r_head == smf_pkg::RING_AW'(smf_pkg::RING_DEPTH - 1))
                     ? '0 : r_head + smf_pkg::RING_AW'(1);

    // Sample ring memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ring[head_next] <= i_q_item.sample;
        end
        if (rd_en) begin
            r_rdata <= r_ring[rd_addr];
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_rd_k       <= '0;
            r_flush_left <= '0;
            r_step       <= '0;
            r_found      <= 1'b0;
            r_from_mem   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_item       <= i_q_item;
                        r_head       <= head_next;
                        r_step       <= '0;
                        r_found      <= 1'b0;
                        if (i_q_item.emit && i_q_item.med) begin
                            r_flush_left <= i_q_item.last ? i_q_item.start : '0;
                            r_state      <= S_COUNT;
                        end else if (i_q_item.emit) begin
                            r_flush_left <= i_q_item.last ? i_q_item.start : '0;
                            r_rd_k       <= i_q_item.half;
                            r_state      <= S_READ;
                        end else if (i_q_item.last) begin
                            r_rd_k       <= i_q_item.start - smf_pkg::HALF_W'(1);
                            r_flush_left <= i_q_item.start - smf_pkg::HALF_W'(1);
                            r_state      <= S_READ;
                        end else begin
                            r_flush_left <= '0;
                        end
                    end
                end
                S_READ: begin
                    r_from_mem <= 1'b1;
                    r_state    <= S_EMIT;
                end
                S_COUNT: begin
                    // One broadcast compare per cycle over the whole window.
                    if (step_last) begin
                        r_step  <= '0;
                        r_state <= S_SELECT;
                    end else begin
                        r_step <= r_step + smf_pkg::LEN_W'(1);
                    end
                end
                S_SELECT: begin
                    // Rotate the window back into place, catching the median at the head.
                    if (med_stat.hit && !r_found) begin
                        r_med   <= med_stat.value;
                        r_found <= 1'b1;
                    end
                    if (step_last) begin
                        r_step     <= '0;
                        r_from_mem <= 1'b0;
                        r_state    <= S_EMIT;
                    end else begin
                        r_step <= r_step + smf_pkg::LEN_W'(1);
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_val   <= r_from_mem ? r_rdata : r_med;
                        r_out_last  <= r_item.last && (r_flush_left == '0);
                        if (r_flush_left != '0) begin
                            r_flush_left <= r_flush_left - smf_pkg::HALF_W'(1);
                            r_from_mem   <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign empty      = !r_out_valid;
    assign o_filtered = r_out_val;
    assign o_last_out = r_out_last;

    // The rotate pass must see the median at the head before the window is back in place.
    a_select_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SELECT && step_last) |-> (r_found || med_stat.hit))
        else $error("median not found in select pass");

    // A waiting result is neither lost nor changed until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out_val) && $stable(r_out_last)))
        else $error("result register changed while waiting");

    // Pass counters stay inside the active window.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT || r_state == S_SELECT) |-> (r_step < len))
        else $error("median pass step outside window");

endmodule

// ----- rtl/sliding_median_filter.sv -----
// Top level of the sliding median filter.
//
// Running median over records of signed Q16.16 samples. The front end takes one sample
// beat per cycle into a four-entry queue whenever full is low; the back end drains that
// queue one sample at a time. A sample that is only stored is taken in the idle state;
// one releasing a raw edge sample needs a ring read and the emit state; one releasing a
// median needs a count pass and a rotate pass over L = 2*min(floor(ws/2), HALF_MAX)+1
// samples for window_size ws, because the median cell array compares one broadcast
// sample against all cells per cycle and then rotates once more to pick the median.
// Each sample flushed at an end marker passes the emit state, which waits on pop. No
// clearing pass runs after reset. Write the window size only while the block is idle.
module sliding_median_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [smf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic signed [smf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                        i_end_of_record,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [smf_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic                        o_last_out
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    smf_pkg::t_item q_in;
    smf_pkg::t_item q_out;

    smf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_end_of_record (i_end_of_record),
        .o_q_push        (q_push),
        .o_q_item        (q_in),
        .i_q_full        (q_full)
    );

    smf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    smf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_q_item   (q_out),
        .empty      (empty),
        .pop        (pop),
        .o_filtered (o_filtered),
        .o_last_out (o_last_out)
    );

endmodule

// ----- tb/smf_checker.sv -----
// Checker for the sliding median filter: predicts every output beat and compares.
module smf_checker
    import smf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  t_sample          i_sample,
    input  logic             i_end_of_record,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_sample          i_filtered,
    input  logic             i_last_out,
    output int               o_pending,
    output int               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // The per-record sample counter saturates at its full range.
    localparam int unsigned SEEN_MAX = (1 << COUNT_W) - 1;
    // A broken design can mismatch on every beat, so only the first ones are printed.
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        t_sample filtered;
        logic    last_out;
    } t_out_beat;

    // Output beats owed by the design, oldest first.
    t_out_beat   due_outputs[$];

    // Own copy of the filter state and the window size register.
    t_sample     history [MAX_WINDOW];
    int unsigned seen_in_record;
    logic [CFG_W-1:0] window_size;

    // Half window, saturated so that the window fits the sample store.
    function automatic int unsigned half_width(input logic [CFG_W-1:0] ws);
        int unsigned h;
        h = ws / 2;
        if (h > HALF_MAX) begin
            h = HALF_MAX;
        end
        return h;
    endfunction

    // Median of the newest 2*h+1 samples, by insertion sort in signed order.
    function automatic t_sample window_median(input int unsigned h);
        t_sample sorted [MAX_WINDOW];
        t_sample v;
        int      len;
        int      i;
        int      j;
        len = 2 * h + 1;
        for (i = 0; i < len; i++) begin
            v = history[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[h];
    endfunction

    // Take one sample beat and queue the output beats it releases.
    task automatic filter_step(input t_sample s, input logic eor);
        int unsigned h;
        int unsigned n;
        int unsigned flush;
        int          k;
        t_out_beat   beat;
        h = half_width(window_size);
        n = seen_in_record;
        for (k = MAX_WINDOW - 1; k > 0; k--) begin
            history[k] = history[k-1];
        end
        history[0] = s;
        if (seen_in_record < SEEN_MAX) begin
            seen_in_record++;
        end

        // At the end marker every sample still held comes out raw.
        flush = 0;
        if (eor) begin
            flush = (n >= h) ? h : n + 1;
        end

        // The sample h places back falls due: median inside the record, raw at its head.
        if (n >= h) begin
            beat.filtered = (n >= 2 * h) ? window_median(h) : history[h];
            beat.last_out = eor && (flush == 0);
            due_outputs.push_back(beat);
        end
        for (k = flush; k > 0; k--) begin
            beat.filtered = history[k-1];
            beat.last_out = (k == 1);
            due_outputs.push_back(beat);
        end
        if (eor) begin
            seen_in_record = 0;
        end
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // Watch all three channels at each rising edge; compare before predicting.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            due_outputs.delete();
            seen_in_record = 0;
            window_size    = WINDOW_RESET;
            o_fail_count   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_size = i_cfg_data;
            end
            if (i_pop && !i_empty) begin
                if (due_outputs.size() == 0) begin
                    report_mismatch("output beat with none owed", i_filtered, 0);
                end else begin
                    want = due_outputs.pop_front();
                    if (i_filtered !== want.filtered) begin
                        report_mismatch("filtered", i_filtered, want.filtered);
                    end
                    if (i_last_out !== want.last_out) begin
                        report_mismatch("last_out", i_last_out, want.last_out);
                    end
                end
            end
            if (i_push && !i_full) begin
                filter_step(i_sample, i_end_of_record);
            end
        end
        o_pending <= due_outputs.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the sliding median filter testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    // The slowest beat is a median over the widest window.
    localparam int SETTLE_CYCLES = 2 * MAX_WINDOW + 50;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = ~SAMPLE_MIN;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0] i_cfg_data      = '0;
    logic             push            = 1'b0;
    t_sample          i_sample        = '0;
    logic             i_end_of_record = 1'b0;
    logic             pop             = 1'b0;
    logic             o_cfg_ready;
    logic             full;
    logic             empty;
    t_sample          o_filtered;
    logic             o_last_out;

    int pending;
    int fail_count;
    int send_idle_pct = 21;
    int recv_idle_pct = 60;
    int stall_cycles  = 0;

    sliding_median_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_end_of_record (i_end_of_record),
        .empty           (empty),
        .pop             (pop),
        .o_filtered      (o_filtered),
        .o_last_out      (o_last_out)
    );

    smf_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_sample        (i_sample),
        .i_end_of_record (i_end_of_record),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_filtered      (o_filtered),
        .i_last_out      (o_last_out),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random, with the current idle share.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: give up when no beat of any channel moves for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly small values near zero so that medians see ties; extremes and wide values too.
    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return t_sample'($urandom());
            default: return t_sample'((int'($urandom_range(0, 15)) - 8) * 65536);
        endcase
    endfunction

    // Offer one sample beat, after random idle cycles, and hold it until accepted.
    task automatic send_item(input t_sample s, input logic eor);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_sample        <= s;
        i_end_of_record <= eor;
        do begin
            @(posedge i_clk);
        end while (full);
        @(negedge i_clk);
    endtask

    // One whole record of random samples.
    task automatic send_record(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_item(random_sample(), i == len - 1);
        end
    endtask

    // Records of random length until the item count is used up.
    task automatic send_records(input int n_items, input int max_len);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, max_len);
            if (len > left) begin
                len = left;
            end
            send_record(len);
            left -= len;
        end
    endtask

    // Drain everything owed, let the back end settle, then set a new window size.
    task automatic new_phase(input logic [CFG_W-1:0] ws, input int send_pct, input int recv_pct);
        push <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ws;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid   <= 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin
        t_sample mixed [9];
        int      i;
        mixed = '{32'sh0003_0000, SAMPLE_MIN, SAMPLE_MAX, -32'sh0005_0000, 32'sh0007_0000,
                  32'sh0007_0000, SAMPLE_MIN, 32'sh0000_0000, 32'sh0002_8000};

        // Reset, released on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset window of 5: a one-sample record, a record too
        // short for the window, then a record with medians over the extremes.
        send_item(SAMPLE_MAX, 1'b1);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b1);
        for (i = 0; i < 9; i++) begin
            send_item(mixed[i], i == 8);
        end

        // Open a record, shrink the window in the middle of it, then finish it.
        send_item(32'sh000A_0000, 1'b0);
        send_item(-32'sh000A_0000, 1'b0);
        send_item(32'sh0014_0000, 1'b0);
        new_phase(CFG_W'(3), 21, 60);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(32'sh0001_0000, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(-32'sh0001_0000, 1'b1);

        // Random records over a range of window sizes, sender idling less than receiver.
        send_records(35, 10);
        new_phase(CFG_W'(0), 21, 60);
        send_records(12, 6);

        // Now the receiver idles less than the sender; 1 passes through, 2 acts as 3.
        new_phase(CFG_W'(1), 60, 21);
        send_records(8, 5);
        new_phase(CFG_W'(2), 60, 21);
        send_records(15, 8);
        new_phase(CFG_W'(8), 60, 21);
        send_records(25, 24);

        // An oversized window acts as the widest; a short record comes out raw.
        new_phase(CFG_W'(127), 60, 21);
        send_record(12);

        // Widest window without idling; the record outruns the saturating counter.
        new_phase(CFG_W'(MAX_WINDOW), 0, 0);
        send_record(130);

        // Wait for every owed beat, then let the block settle.
        push <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
